>>> src/knn_pkg.sv
// Shared types and constants for the k-nearest-neighbor majority vote block.
`timescale 1ns / 1ps
`default_nettype none

package knn_pkg;

    localparam int NUM_CLASSES_DEF = 64;
    localparam int MAX_K_DEF       = 64;

    localparam int CLASS_W   = 6;
    localparam int VOTES_W   = 7;
    localparam int NCOUNT_W  = 7;
    localparam int CLS_IDX_W = 10;
    localparam int CNT_W     = 11;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 7'd5;

    localparam logic [APB_ADDR_W-3:0] REG_NEIGHBOUR_COUNT = 1'b0;

    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        logic               entry_valid;
        logic               last_entry;
    } knn_in_t;

    typedef struct packed {
        logic [CLASS_W-1:0] winner_class;
        logic [VOTES_W-1:0] winner_votes;
        logic               found;
    } knn_out_t;

    typedef struct packed {
        logic                 valid;
        logic                 vote;
        logic                 last;
        logic [CLS_IDX_W-1:0] cls;
        logic [CNT_W-1:0]     pos;
        logic [CNT_W-1:0]     cnt;
        logic [CNT_W-1:0]     fpos;
    } knn_item_t;

endpackage

`default_nettype wire

>>> src/knn_cell.sv
// One class cell: vote count and first vote position, passes the item on.
`timescale 1ns / 1ps
`default_nettype none

module knn_cell
    import knn_pkg::*;
#(
    parameter int CELL_ID = 0
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  wire knn_item_t item_in,
    output knn_item_t      item_out
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] fpos_reg;
    logic [CNT_W-1:0] fpos_next;
    knn_item_t        item_reg;
    knn_item_t        item_next;
    logic             hit;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] fpos_hit;

    assign hit      = item_in.valid && item_in.vote && (item_in.cls == CLS_IDX_W'(CELL_ID));
    assign cnt_inc  = count_reg + CNT_W'(1);
    assign fpos_hit = (count_reg == '0) ? item_in.pos : fpos_reg;

    always_comb begin
        item_next  = item_in;
        count_next = count_reg;
        fpos_next  = fpos_reg;
        if (hit) begin
            item_next.cnt  = cnt_inc;
            item_next.fpos = fpos_hit;
            count_next     = cnt_inc;
            fpos_next      = fpos_hit;
        end
        if (item_in.valid && item_in.last) begin
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            item_reg.valid <= 1'b0;
        end else if (advance) begin
            count_reg <= count_next;
            item_reg  <= item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fpos_reg <= fpos_next;
        end
    end

    assign item_out = item_reg;

endmodule

`default_nettype wire

>>> src/knn_tally.sv
// Chain tail: running best in item order and the result output register.
`timescale 1ns / 1ps
`default_nettype none

module knn_tally
    import knn_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire knn_item_t item_in,
    output logic           pipe_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output knn_out_t       m_data
);

    logic [CLS_IDX_W-1:0] best_class_reg;
    logic [CLS_IDX_W-1:0] best_class_next;
    logic [CNT_W-1:0]     best_votes_reg;
    logic [CNT_W-1:0]     best_votes_next;
    logic [CNT_W-1:0]     best_pos_reg;
    logic [CNT_W-1:0]     best_pos_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    knn_out_t             m_data_reg;
    knn_out_t             m_data_next;
    logic                 take;
    logic                 better;
    logic [CLS_IDX_W-1:0] upd_class;
    logic [CNT_W-1:0]     upd_votes;
    logic [CNT_W-1:0]     upd_pos;

    assign pipe_ready = !(item_in.valid && item_in.last && m_valid_reg && !m_ready);
    assign take       = pipe_ready && item_in.valid;
    assign better     = item_in.vote && ((item_in.cnt > best_votes_reg) ||
                        ((item_in.cnt == best_votes_reg) && (item_in.fpos < best_pos_reg)));

    always_comb begin
        upd_class = best_class_reg;
        upd_votes = best_votes_reg;
        upd_pos   = best_pos_reg;
        if (better) begin
            upd_class = item_in.cls;
            upd_votes = item_in.cnt;
            upd_pos   = item_in.fpos;
        end
    end

    always_comb begin
        best_class_next = best_class_reg;
        best_votes_next = best_votes_reg;
        best_pos_next   = best_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        if (take) begin
            if (item_in.last) begin
                best_class_next          = '0;
                best_votes_next          = '0;
                best_pos_next            = '0;
                m_valid_next             = 1'b1;
                m_data_next.found        = (upd_votes != '0);
                m_data_next.winner_class = (upd_votes != '0) ? CLASS_W'(upd_class) : '0;
                m_data_next.winner_votes = (upd_votes != '0) ? VOTES_W'(upd_votes) : '0;
            end else begin
                best_class_next = upd_class;
                best_votes_next = upd_votes;
                best_pos_next   = upd_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_class_reg <= '0;
            best_votes_reg <= '0;
            best_pos_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            best_class_reg <= best_class_next;
            best_votes_reg <= best_votes_next;
            best_pos_reg   <= best_pos_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> src/knn_majority_vote.sv
// Top level of the k-nearest-neighbor majority vote block.
`timescale 1ns / 1ps
`default_nettype none

// Takes one ranked neighbor item per cycle, best first. The first neighbour_count
// valid entries with a class below NUM_CLASSES vote (neighbour_count is capped at
// MAX_K). On the item marked last_entry the block delivers one result: the class
// with most votes, ties going to the class whose first vote came earliest, or
// found = 0 with zero fields when nothing voted. Items flow through a head stage,
// a row of NUM_CLASSES cells (one per class) and a tally stage with the result
// output register. The input takes one item per cycle; it stalls only while a
// finished result is not taken and another last item has reached the tally stage.
// neighbour_count sits at byte address 0 of the APB port and resets to 5; write it
// only while the block is idle.
module knn_majority_vote
    import knn_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int MAX_K       = MAX_K_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire knn_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output knn_out_t                   m_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [NCOUNT_W-1:0] ncount_reg;
    logic [NCOUNT_W-1:0] ncount_next;
    logic [CNT_W-1:0]    taken_reg;
    logic [CNT_W-1:0]    taken_next;
    logic [CNT_W-1:0]    limit;
    logic                advance;
    logic                accept;
    logic                in_vote;
    knn_item_t           head_reg;
    knn_item_t           head_next;
    knn_item_t           chain [NUM_CLASSES+1];

    // configuration port
    assign pready = 1'b1;

    always_comb begin
        ncount_next = ncount_reg;
        if (psel && penable && pwrite && pready &&
            (paddr[APB_ADDR_W-1:2] == REG_NEIGHBOUR_COUNT)) begin
            ncount_next = pwdata[NCOUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == REG_NEIGHBOUR_COUNT) begin
            prdata = APB_DATA_W'(ncount_reg);
        end
    end

    // head stage: decide who votes and at which rank
    assign s_ready = advance;
    assign accept  = s_valid && advance;
    assign limit   = (CNT_W'(ncount_reg) > CNT_W'(MAX_K)) ? CNT_W'(MAX_K) : CNT_W'(ncount_reg);
    assign in_vote = s_data.entry_valid && (32'(s_data.class_id) < 32'(NUM_CLASSES)) &&
                     (taken_reg < limit);

    always_comb begin
        head_next.valid = s_valid;
        head_next.vote  = in_vote;
        head_next.last  = s_data.last_entry;
        head_next.cls   = CLS_IDX_W'(s_data.class_id);
        head_next.pos   = taken_reg;
        head_next.cnt   = '0;
        head_next.fpos  = '0;
        taken_next      = taken_reg;
        if (accept) begin
            if (in_vote) begin
                taken_next = taken_reg + CNT_W'(1);
            end
            if (s_data.last_entry) begin
                taken_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncount_reg     <= NCOUNT_RESET;
            taken_reg      <= '0;
            head_reg.valid <= 1'b0;
        end else begin
            ncount_reg <= ncount_next;
            taken_reg  <= taken_next;
            if (advance) begin
                head_reg <= head_next;
            end
        end
    end

    // class cells
    assign chain[0] = head_reg;

    for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_cell
        knn_cell #(
            .CELL_ID (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .item_in  (chain[i]),
            .item_out (chain[i+1])
        );
    end

    knn_tally u_tally (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_in    (chain[NUM_CLASSES]),
        .pipe_ready (advance),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef SYNTHESIS
    a_nofound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> (m_data.winner_votes == '0 && m_data.winner_class == '0))
        else $error("empty result carries nonzero fields");

    a_found_votes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.found) |-> (m_data.winner_votes != '0))
        else $error("winner reported without votes");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a pending result");

    a_taken_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_vote) |=> (taken_reg <= CNT_W'(MAX_K)))
        else $error("vote rank beyond cap");
`endif

endmodule

`default_nettype wire
